FILE: src/refcounted_shared_page_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shared page table
// Clocked assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SHARED_PAGE_TABLE_MACROS_SVH
`define REFCOUNTED_SHARED_PAGE_TABLE_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define RSPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define RSPT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rspt_pkg.sv
// ----------------------------------------------------------------------------
// Shared page table package
// Widths, command and status codes, controller types and helpers.
// ----------------------------------------------------------------------------
package rspt_pkg;

   // Defaults for the top level parameters
   localparam int SLOTS_DEFAULT      = 16;
   localparam int FRAME_BITS_DEFAULT = 44;

   // Field widths
   localparam int CMD_W    = 3;
   localparam int SLOT_W   = 8;
   localparam int FRAME_W  = 44;
   localparam int PERM_W   = 8;
   localparam int STATUS_W = 3;
   localparam int REFS_W   = 8;

   // Stream widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   // Free slot search works on groups of valid bits
   localparam int GROUP_SIZE = 16;
   localparam int GROUP_LSB_W = 4;

   // Reference count ceiling
   localparam logic [REFS_W-1:0] REFS_MAX = '1;

   // Commands
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ATTACH = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DETACH = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET    = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FRAME_FAIL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_EXEC,
      S_DONE
   } rspt_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic find;
      logic exec;
      logic load_rsp;
   } rspt_ctl_type;

   // Lowest set bit of a group: {found, index}
   function automatic logic [GROUP_LSB_W:0] first_set(input logic [GROUP_SIZE-1:0] v);
      logic [GROUP_LSB_W:0] r;
      r = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = {1'b1, GROUP_LSB_W'(i)};
         end
      end
      return r;
   endfunction

endpackage

FILE: src/refcounted_shared_page_table.sv
// ----------------------------------------------------------------------------
// Reference counted shared page table
// Slot allocator with per-slot frame, reference count and permission code.
//
// Usage:
//   Commands arrive on the req_ stream; req_tuser carries the command code,
//   req_tdata the slot id, offered frame, frame usable flag and permission.
//   Every command yields exactly one response on the rsp_ stream with a
//   status code, claimed slot, permission, frame and taken/released flags.
//   On the way from request acceptance to rsp_tvalid the request is
//   latched at the accepting edge, then the search state picks the lowest
//   group with a free slot while the slot RAMs are read, the execute state
//   does the read-modify-write and the done state loads the output register.
//   This sequencer handles one command at a time and returns to idle
//   before the next.
//   A new request is accepted while the previous response still waits in
//   the output register. If the receiver stalls, the finished result waits
//   in the datapath result register and no new request is taken until the
//   output register frees up.
//   Synchronous reset frees every slot and clears the permission-written
//   flags, so permissions read as zero until set; a claim rewrites the
//   count. The block accepts commands in the next cycle.
// ----------------------------------------------------------------------------
module refcounted_shared_page_table import rspt_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEFAULT,
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // slot[8], frame_in[44], frame_ok[1], perm_value[8]
   input  logic [CMD_W-1:0]      req_tuser,  // cmd[3]
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[3], slot_out[8], perm_out[8],
                                             // frame_out[44], frame_taken[1],
                                             // frame_released[1]
);

   rspt_ctl_type ctl;

   // sequencer
   rspt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   // slot table and result path
   rspt_dpath #(.SLOTS(SLOTS), .FRAME_BITS(FRAME_BITS)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_cmd  (req_tuser),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule

FILE: src/rspt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rspt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rspt_ctrl.sv
// ----------------------------------------------------------------------------
// Shared page table controller
// Sequences one transaction: accept, search, execute, hand off result.
// ----------------------------------------------------------------------------
module rspt_ctrl import rspt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rspt_ctl_type ctl
);

   rspt_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // output register can take a new result
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            ctl.load_req = req_tvalid;
         end
         S_FIND: begin
            ctl.find = 1'b1;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
         end
         S_DONE: begin
            ctl.load_rsp = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: src/rspt_dpath.sv
// ----------------------------------------------------------------------------
// Shared page table datapath
// Slot valid bits, free slot search, slot RAMs and result registers.
// ----------------------------------------------------------------------------
module rspt_dpath import rspt_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEFAULT,
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rspt_ctl_type          ctl,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [REQ_DATA_W-1:0] req_data,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int STORE_W = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;
   localparam int GROUPS  = (SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAD     = GROUPS * GROUP_SIZE;

   // latched request
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [STORE_W-1:0] frame_ff, frame_in;
   logic               fok_ff, fok_in;
   logic [PERM_W-1:0]  pval_ff, pval_in;

   // slot state held in flops
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] perm_set_ff, perm_set_in;

   // group search result
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic             any_ff, any_in;

   // result and output registers
   logic [RSP_DATA_W-1:0] res_ff, res_in;
   logic [RSP_DATA_W-1:0] out_ff, out_in;

   logic [PAD-1:0]        valid_pad;
   logic [GROUPS-1:0]     grp_free;
   logic [GROUP_LSB_W:0]  low_hit;
   logic [IDX_W-1:0]      free_idx;
   logic [IDX_W-1:0]      id_idx;
   logic                  id_ok;

   logic [STORE_W-1:0] frame_rd;
   logic [REFS_W-1:0]  refs_rd;
   logic [PERM_W-1:0]  perm_rd;

   logic               frame_we, refs_we, perm_we;
   logic [IDX_W-1:0]   refs_addr;
   logic [REFS_W-1:0]  refs_wd;
   logic               get_ok, det_free;

   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_o;
   logic [PERM_W-1:0]   perm_o;
   logic [FRAME_W-1:0]  frame_o;
   logic                taken, released;

   // request latch
   always_comb begin
      cmd_in   = cmd_ff;
      slot_in  = slot_ff;
      frame_in = frame_ff;
      fok_in   = fok_ff;
      pval_in  = pval_ff;
      if (ctl.load_req) begin
         cmd_in   = req_cmd;
         slot_in  = req_data[7:0];
         frame_in = req_data[8 +: STORE_W];
         fok_in   = req_data[52];
         pval_in  = req_data[60:53];
      end
   end

   // pad past the table counts as taken
   always_comb begin
      valid_pad = '1;
      valid_pad[SLOTS-1:0] = valid_ff;
   end

   // first level: lowest group with a free slot
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_free[g] = ~&valid_pad[g*GROUP_SIZE +: GROUP_SIZE];
      end
      grp_in = grp_ff;
      any_in = any_ff;
      if (ctl.find) begin
         grp_in = '0;
         any_in = 1'b0;
         for (int g = GROUPS - 1; g >= 0; g--) begin
            if (grp_free[g]) begin
               grp_in = GRP_W'(g);
               any_in = 1'b1;
            end
         end
      end
   end

   // second level: lowest free slot inside the chosen group
   assign low_hit  = first_set(~valid_pad[grp_ff*GROUP_SIZE +: GROUP_SIZE]);
   assign free_idx = IDX_W'({grp_ff, low_hit[GROUP_LSB_W-1:0]});

   // id check
   assign id_idx = slot_ff[IDX_W-1:0];
   assign id_ok  = ({1'b0, slot_ff} < (SLOT_W+1)'(SLOTS)) && valid_pad[id_idx];

   // command execution
   always_comb begin
      status    = ST_OK;
      slot_o    = '0;
      perm_o    = '0;
      frame_o   = '0;
      taken     = 1'b0;
      released  = 1'b0;
      frame_we  = 1'b0;
      refs_we   = 1'b0;
      perm_we   = 1'b0;
      refs_addr = id_idx;
      refs_wd   = '0;
      get_ok    = 1'b0;
      det_free  = 1'b0;
      unique case (cmd_ff)
         CMD_GET: begin
            if (!any_ff) begin
               status = ST_NO_SLOT;
            end else if (!fok_ff) begin
               status = ST_FRAME_FAIL;
            end else begin
               get_ok    = 1'b1;
               frame_we  = 1'b1;
               refs_we   = 1'b1;
               refs_addr = free_idx;
               refs_wd   = '0;
               slot_o    = SLOT_W'(free_idx);
               taken     = 1'b1;
            end
         end
         CMD_ATTACH: begin
            if (!id_ok) begin
               status = ST_BAD_ID;
            end else if (refs_rd == REFS_MAX) begin
               status = ST_FULL;
            end else begin
               refs_we = 1'b1;
               refs_wd = refs_rd + REFS_W'(1);
               frame_o = FRAME_W'(frame_rd);
            end
         end
         CMD_DETACH: begin
            if (!id_ok) begin
               status = ST_BAD_ID;
            end else begin
               // a count of one or zero frees the slot; zero is not wrapped
               refs_we  = (refs_rd != '0);
               refs_wd  = refs_rd - REFS_W'(1);
               det_free = (refs_rd <= REFS_W'(1));
               if (det_free) begin
                  frame_o  = FRAME_W'(frame_rd);
                  released = 1'b1;
               end
            end
         end
         CMD_QUERY: begin
            if (!id_ok) begin
               status = ST_BAD_ID;
            end else if (perm_set_ff[id_idx]) begin
               perm_o = perm_rd;
            end
         end
         CMD_SET: begin
            if (!id_ok) begin
               status = ST_BAD_ID;
            end else begin
               perm_we = 1'b1;
            end
         end
         default: begin
            status = ST_BAD_ID;
         end
      endcase
   end

   // slot flags
   always_comb begin
      valid_in    = valid_ff;
      perm_set_in = perm_set_ff;
      if (ctl.exec && get_ok) begin
         valid_in[free_idx] = 1'b1;
      end
      if (ctl.exec && det_free) begin
         valid_in[id_idx] = 1'b0;
      end
      if (ctl.exec && perm_we) begin
         perm_set_in[id_idx] = 1'b1;
      end
   end

   // result packing, status in the low bits
   always_comb begin
      res_in = res_ff;
      if (ctl.exec) begin
         res_in = RSP_DATA_W'({released, taken, frame_o, perm_o, slot_o, status});
      end
      out_in = out_ff;
      if (ctl.load_rsp) begin
         out_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         perm_set_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         perm_set_ff <= perm_set_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      slot_ff  <= slot_in;
      frame_ff <= frame_in;
      fok_ff   <= fok_in;
      pval_ff  <= pval_in;
      grp_ff   <= grp_in;
      any_ff   <= any_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   // slot stores
   rspt_ram #(.WIDTH(STORE_W), .DEPTH(SLOTS)) u_frame_ram (
      .clock   (clock),
      .wr_en   (ctl.exec && frame_we),
      .wr_addr (free_idx),
      .wr_data (frame_ff),
      .rd_addr (id_idx),
      .rd_data (frame_rd)
   );

   rspt_ram #(.WIDTH(REFS_W), .DEPTH(SLOTS)) u_refs_ram (
      .clock   (clock),
      .wr_en   (ctl.exec && refs_we),
      .wr_addr (refs_addr),
      .wr_data (refs_wd),
      .rd_addr (id_idx),
      .rd_data (refs_rd)
   );

   rspt_ram #(.WIDTH(PERM_W), .DEPTH(SLOTS)) u_perm_ram (
      .clock   (clock),
      .wr_en   (ctl.exec && perm_we),
      .wr_addr (id_idx),
      .wr_data (pval_ff),
      .rd_addr (id_idx),
      .rd_data (perm_rd)
   );

   assign rsp_data = out_ff;

endmodule

FILE: src/rspt_checker.sv
// ----------------------------------------------------------------------------
// Shared page table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcounted_shared_page_table_macros.svh"

module rspt_checker import rspt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [CMD_W-1:0]      req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled response keeps its valid and payload
   `RSPT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")
   `RSPT_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp payload changed while stalled")

   // no response straight out of reset
   `RSPT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   // one command in flight: ready drops after acceptance
   `RSPT_ASSERT(a_one_inflight, clock, reset, req_tvalid && req_tready |=> !req_tready, "second request taken while busy")

   // a stored frame means ok status, and never together with a release
   `RSPT_ASSERT(a_taken_ok, clock, reset, rsp_tvalid && rsp_tdata[63] |-> (rsp_tdata[2:0] == ST_OK) && !rsp_tdata[64], "frame taken with bad status or release")

endmodule

bind refcounted_shared_page_table rspt_checker u_rspt_checker (.*);
